[rtl/smx_pkg.sv]
package smx_pkg;

    localparam int MAX_LEN     = 16;
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int IDX_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SAMPLE_W    = 16;
    localparam int PROB_W      = 15;
    localparam int EXP_W       = 18;
    localparam int SUM_W       = 22;
    localparam int FRAC_BITS   = 46;
    localparam int OUT_SHIFT   = 30;
    localparam int TERM_W      = 47;
    localparam int ACC_W       = 48;
    localparam int PROD_W      = 63;
    localparam int K_W         = 6;
    localparam int TERM_LIMIT  = 40;
    localparam int DIV_CNT_W   = 6;
    localparam int MUL_CNT_W   = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_STORE,
        ST_OUT_RD,
        ST_OUT_GO,
        ST_OUT_DIV,
        ST_OUT_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic div_exp;
        logic acc_upd;
        logic store;
        logic out_init;
        logic rd;
        logic div_out;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic room;
        logic last;
        logic mul_done;
        logic div_done;
        logic q_zero;
        logic k_last;
        logic out_last;
    } t_stat;

endpackage

[rtl/smx_div.sv]
module smx_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [smx_pkg::PROD_W-1:0]      i_dividend,
    input  logic [smx_pkg::SUM_W-1:0]       i_divisor,
    output logic                            o_done,
    output logic [smx_pkg::PROD_W-1:0]      o_quot
);

    logic [smx_pkg::PROD_W-1:0]    r_q, n_q;
    logic [smx_pkg::SUM_W-1:0]     r_rem, n_rem;
    logic [smx_pkg::SUM_W-1:0]     r_dvs;
    logic [smx_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [smx_pkg::SUM_W:0]       trial;
    logic [smx_pkg::SUM_W:0]       diff;

    always_comb begin
        trial  = {r_rem, r_q[smx_pkg::PROD_W-1]};
        diff   = trial - {1'b0, r_dvs};
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_cnt  = smx_pkg::DIV_CNT_W'(smx_pkg::PROD_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[smx_pkg::SUM_W-1:0];
                n_q   = {r_q[smx_pkg::PROD_W-2:0], 1'b1};
            end else begin
                n_rem = trial[smx_pkg::SUM_W-1:0];
                n_q   = {r_q[smx_pkg::PROD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == smx_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[rtl/smx_dp.sv]
module smx_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smx_pkg::t_cmd                     i_cmd,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_last_in,
    output smx_pkg::t_stat                    o_stat,
    output logic                              o_valid,
    output logic [smx_pkg::PROB_W-1:0]        o_prob,
    output logic                              o_last_out
);

    logic [smx_pkg::EXP_W-1:0]    mem [smx_pkg::MAX_LEN];
    logic [smx_pkg::TERM_W-1:0]   r_term;
    logic [smx_pkg::ACC_W-1:0]    r_acc;
    logic [smx_pkg::K_W-1:0]      r_k;
    logic                         r_neg;
    logic                         r_last;
    logic [smx_pkg::SAMPLE_W-1:0] r_mag;
    logic [smx_pkg::PROD_W-1:0]   r_prod;
    logic [smx_pkg::SAMPLE_W-1:0] r_mplier;
    logic [smx_pkg::MUL_CNT_W-1:0] r_mcnt;
    logic                         r_mbusy;
    logic                         r_mdone;
    logic [smx_pkg::CNT_W-1:0]    r_count;
    logic [smx_pkg::SUM_W-1:0]    r_sum;
    logic [smx_pkg::CNT_W-1:0]    r_idx;
    logic [smx_pkg::EXP_W-1:0]    r_rd;
    logic                         r_valid;
    logic [smx_pkg::PROB_W-1:0]   r_prob;
    logic                         r_lastout;

    logic [smx_pkg::SAMPLE_W-1:0] raw;
    logic [smx_pkg::SAMPLE_W-1:0] mag;
    logic [20:0]                  kdiv;
    logic [32:0]                  scaled;
    logic                         div_start;
    logic [smx_pkg::PROD_W-1:0]   div_dend;
    logic [smx_pkg::SUM_W-1:0]    div_dvs;
    logic                         div_done;
    logic [smx_pkg::PROD_W-1:0]   quot;
    logic [smx_pkg::TERM_W-1:0]   q_term;
    logic [smx_pkg::EXP_W-1:0]    e_new;
    logic                         out_last;

    assign raw    = i_sample;
    assign mag    = raw[smx_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    assign kdiv   = {r_k, 15'd0} - {15'd0, r_k};
    assign scaled = {r_rd, 15'd0} - {15'd0, r_rd};
    assign q_term = quot[smx_pkg::TERM_W-1:0];
    assign e_new  = r_acc[smx_pkg::OUT_SHIFT +: smx_pkg::EXP_W];
    assign out_last = (r_idx + 1'b1) == r_count;

    assign div_start = i_cmd.div_exp | i_cmd.div_out;
    assign div_dend  = i_cmd.div_exp ? r_prod
                                     : {{(smx_pkg::PROD_W-33){1'b0}}, scaled};
    assign div_dvs   = i_cmd.div_exp ? {1'b0, kdiv} : r_sum;

    smx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dend),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
            r_mbusy   <= 1'b0;
            r_mdone   <= 1'b0;
            r_mcnt    <= '0;
            r_valid   <= 1'b0;
            r_k       <= '0;
        end else begin
            r_mdone <= r_mbusy && (r_mcnt == smx_pkg::MUL_CNT_W'(1));
            r_valid <= i_cmd.emit;
            if (i_cmd.load) begin
                r_k <= smx_pkg::K_W'(1);
            end
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= smx_pkg::MUL_CNT_W'(smx_pkg::SAMPLE_W);
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt - 1'b1;
                if (r_mcnt == smx_pkg::MUL_CNT_W'(1)) begin
                    r_mbusy <= 1'b0;
                end
            end
            if (i_cmd.acc_upd) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.store) begin
                r_sum   <= r_sum + {{(smx_pkg::SUM_W-smx_pkg::EXP_W){1'b0}}, e_new};
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.out_init) begin
                r_idx <= '0;
            end
            if (i_cmd.emit) begin
                r_idx   <= r_idx + 1'b1;
                if (out_last) begin
                    r_count <= '0;
                    r_sum   <= '0;
                end
            end
        end
        if (i_cmd.load) begin
            r_neg  <= raw[smx_pkg::SAMPLE_W-1];
            r_mag  <= mag;
            r_last <= i_last_in;
            r_term <= smx_pkg::TERM_W'(1) << smx_pkg::FRAC_BITS;
            r_acc  <= smx_pkg::ACC_W'(1) << smx_pkg::FRAC_BITS;
        end
        if (i_cmd.mul_start) begin
            r_prod   <= '0;
            r_mplier <= r_mag;
        end else if (r_mbusy) begin
            r_prod   <= {r_prod[smx_pkg::PROD_W-2:0], 1'b0}
                      + (r_mplier[smx_pkg::SAMPLE_W-1]
                         ? {{(smx_pkg::PROD_W-smx_pkg::TERM_W){1'b0}}, r_term}
                         : '0);
            r_mplier <= {r_mplier[smx_pkg::SAMPLE_W-2:0], 1'b0};
        end
        if (i_cmd.acc_upd) begin
            r_term <= q_term;
            if (r_neg && r_k[0]) begin
                r_acc <= r_acc - {1'b0, q_term};
            end else begin
                r_acc <= r_acc + {1'b0, q_term};
            end
        end
        if (i_cmd.store) begin
            mem[r_count[smx_pkg::IDX_W-1:0]] <= e_new;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_idx[smx_pkg::IDX_W-1:0]];
        end
        if (i_cmd.emit) begin
            r_prob    <= quot[smx_pkg::PROB_W-1:0];
            r_lastout <= out_last;
        end
    end

    always_comb begin
        o_stat.room     = r_count < smx_pkg::CNT_W'(smx_pkg::MAX_LEN);
        o_stat.last     = r_last;
        o_stat.mul_done = r_mdone;
        o_stat.div_done = div_done;
        o_stat.q_zero   = quot == '0;
        o_stat.k_last   = r_k == smx_pkg::K_W'(smx_pkg::TERM_LIMIT);
        o_stat.out_last = out_last;
    end

    assign o_valid    = r_valid;
    assign o_prob     = r_prob;
    assign o_last_out = r_lastout;

endmodule

[rtl/smx_ctrl.sv]
module smx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last_in,
    input  smx_pkg::t_stat i_stat,
    output smx_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    smx_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smx_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = r_state != smx_pkg::ST_IDLE;
        unique case (r_state)
            smx_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_stat.room) begin
                        o_cmd.load = 1'b1;
                        n_state    = smx_pkg::ST_MUL_GO;
                    end else if (i_last_in) begin
                        o_cmd.out_init = 1'b1;
                        n_state        = smx_pkg::ST_OUT_RD;
                    end
                end
            end
            smx_pkg::ST_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                n_state         = smx_pkg::ST_MUL;
            end
            smx_pkg::ST_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.div_exp = 1'b1;
                    n_state       = smx_pkg::ST_DIV;
                end
            end
            smx_pkg::ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = smx_pkg::ST_ACC;
                end
            end
            smx_pkg::ST_ACC: begin
                o_cmd.acc_upd = !i_stat.q_zero;
                if (i_stat.q_zero || i_stat.k_last) begin
                    n_state = smx_pkg::ST_STORE;
                end else begin
                    n_state = smx_pkg::ST_MUL_GO;
                end
            end
            smx_pkg::ST_STORE: begin
                o_cmd.store = 1'b1;
                if (i_stat.last) begin
                    o_cmd.out_init = 1'b1;
                    n_state        = smx_pkg::ST_OUT_RD;
                end else begin
                    n_state = smx_pkg::ST_IDLE;
                end
            end
            smx_pkg::ST_OUT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = smx_pkg::ST_OUT_GO;
            end
            smx_pkg::ST_OUT_GO: begin
                o_cmd.div_out = 1'b1;
                n_state       = smx_pkg::ST_OUT_DIV;
            end
            smx_pkg::ST_OUT_DIV: begin
                if (i_stat.div_done) begin
                    n_state = smx_pkg::ST_OUT_EMIT;
                end
            end
            smx_pkg::ST_OUT_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.out_last) begin
                    n_state = smx_pkg::ST_IDLE;
                end else begin
                    n_state = smx_pkg::ST_OUT_RD;
                end
            end
            default: begin
                n_state = smx_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/q15_softmax_vector_top.sv]
// channel  | signals                                   | handshake
// ---------+-------------------------------------------+------------------------------
// input    | i_sample[15:0] signed, i_last_in          | taken when start && !busy
// result   | o_prob[14:0], o_last_out                  | o_valid for one cycle
//
// Each sample runs a Taylor exponent on one shift-add multiplier and one radix-2
// divider per term, 1 to 17 terms over the Q15 range; busy stays high until the
// exponent is stored, and after a last word until every result is emitted.
// Each result takes one divider pass plus read and emit.
// Synchronous active-low reset clears control; the receiver cannot stall.
module q15_softmax_vector_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last_in,
    output logic                                o_valid,
    output logic [smx_pkg::PROB_W-1:0]          o_prob,
    output logic                                o_last_out
);

    smx_pkg::t_cmd  cmd;
    smx_pkg::t_stat stat;

    smx_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_last_in (i_last_in),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    smx_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_sample   (i_sample),
        .i_last_in  (i_last_in),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_prob     (o_prob),
        .o_last_out (o_last_out)
    );

endmodule

[test/q15_softmax_vector_checker.sv]
module q15_softmax_vector_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last_in,
    input  logic                                o_valid,
    input  logic [smx_pkg::PROB_W-1:0]          o_prob,
    input  logic                                o_last_out,
    output int                                  errors,
    output int                                  pending,
    output int                                  results_seen
);

    typedef struct {
        logic [smx_pkg::PROB_W-1:0] prob;
        logic                       last_out;
    } t_share;

    t_share                     share_q[$];
    logic [smx_pkg::EXP_W-1:0]  exp_mem [smx_pkg::MAX_LEN];
    logic [31:0]                exp_total;
    int                         n_stored;

    function automatic logic [smx_pkg::EXP_W-1:0] taylor_exp(
        logic [smx_pkg::SAMPLE_W-1:0] bits);
        longint unsigned mag, acc, term;
        logic neg;
        neg  = bits[smx_pkg::SAMPLE_W-1];
        mag  = neg ? (64'd65536 - bits) : bits;
        acc  = 64'd1 << smx_pkg::FRAC_BITS;
        term = acc;
        for (int k = 1; k <= smx_pkg::TERM_LIMIT; k++) begin
            term = (term * mag) / (64'd32767 * k);
            if (term == 0)
                break;
            if (neg && (k % 2 == 1))
                acc = acc - term;
            else
                acc = acc + term;
        end
        return smx_pkg::EXP_W'(acc >> smx_pkg::OUT_SHIFT);
    endfunction

    task automatic take_sample(logic [smx_pkg::SAMPLE_W-1:0] s, logic fin);
        t_share r;
        longint unsigned p;
        if (n_stored < smx_pkg::MAX_LEN) begin
            exp_mem[n_stored] = taylor_exp(s);
            exp_total = exp_total + exp_mem[n_stored];
            n_stored++;
        end
        if (fin) begin
            for (int i = 0; i < n_stored; i++) begin
                p = (64'd32767 * exp_mem[i]) / exp_total;
                if (p > 32767)
                    p = 32767;
                r.prob     = smx_pkg::PROB_W'(p);
                r.last_out = (i + 1 == n_stored);
                share_q.push_back(r);
            end
            exp_total = 0;
            n_stored  = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_share want;
        if (!i_rst_n) begin
            exp_total = 0;
            n_stored  = 0;
            share_q.delete();
            pending   = 0;
        end else begin
            if (o_valid) begin
                results_seen++;
                if (share_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word prob=%0d last=%0b", $time, o_prob,
                             o_last_out);
                end else begin
                    want = share_q.pop_front();
                    if (want.prob !== o_prob) begin
                        errors++;
                        $display("%0t: prob expected %0d actual %0d", $time, want.prob,
                                 o_prob);
                    end
                    if (want.last_out !== o_last_out) begin
                        errors++;
                        $display("%0t: last_out expected %0b actual %0b", $time,
                                 want.last_out, o_last_out);
                    end
                end
            end
            if (start && !busy)
                take_sample(i_sample, i_last_in);
            pending = share_q.size();
        end
    end
endmodule

[test/q15_softmax_vector_top_tb.sv]
module q15_softmax_vector_top_tb;

    localparam int WATCHDOG_LIMIT = 40000;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic signed [smx_pkg::SAMPLE_W-1:0]  i_sample;
    logic                                 i_last_in;
    logic                                 o_valid;
    logic [smx_pkg::PROB_W-1:0]           o_prob;
    logic                                 o_last_out;
    int                                   errors, pending, results_seen;
    int                                   idle_pct;
    int                                   words_sent;
    int                                   vectors_sent;
    int                                   quiet_cycles;

    q15_softmax_vector_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sample(i_sample), .i_last_in(i_last_in), .o_valid(o_valid),
        .o_prob(o_prob), .o_last_out(o_last_out)
    );

    q15_softmax_vector_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sample(i_sample), .i_last_in(i_last_in), .o_valid(o_valid),
        .o_prob(o_prob), .o_last_out(o_last_out), .errors(errors),
        .pending(pending), .results_seen(results_seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid || !i_rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_word(logic [smx_pkg::SAMPLE_W-1:0] s, logic fin);
        logic was_busy;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_sample  <= s;
        i_last_in <= fin;
        forever begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
            if (!was_busy)
                break;
        end
        words_sent++;
        if (fin)
            vectors_sent++;
    endtask

    function automatic logic [smx_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return smx_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_vector(int len);
        for (int i = 0; i < len; i++)
            send_word(pick_sample(), i == len - 1);
    endtask

    initial begin
        int len;
        i_rst_n = 0;
        start = 0;
        i_sample = 0;
        i_last_in = 0;
        idle_pct = 32;
        words_sent = 0;
        vectors_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single element, extremes, overlong vector closed by a dropped word
        send_word(16'h0000, 1'b1);
        send_word(16'h7FFF, 1'b1);
        send_word(16'h8000, 1'b1);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b1);
        for (int i = 0; i < 18; i++)
            send_word(i[0] ? 16'h7FFF : 16'h8000, i == 17);

        while (words_sent < 280) begin
            if (words_sent > 93)
                idle_pct = (words_sent > 186) ? 0 : 86;
            len = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 8);
            send_vector(len);
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0 || busy)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d words in %0d vectors, checked %0d result words.",
                 words_sent, vectors_sent, results_seen);
        $display("Covered full-scale samples, single and overlong vectors, and three idle mixes.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[filelist.f]
rtl/smx_pkg.sv
rtl/smx_div.sv
rtl/smx_dp.sv
rtl/smx_ctrl.sv
rtl/q15_softmax_vector_top.sv
test/q15_softmax_vector_checker.sv
test/q15_softmax_vector_top_tb.sv
